// File: design/ring_cellular_automaton_cycle_check_defines.svh
// Assertion helpers used by the checker file.
`ifndef RING_CELLULAR_AUTOMATON_CYCLE_CHECK_DEFINES_SVH
`define RING_CELLULAR_AUTOMATON_CYCLE_CHECK_DEFINES_SVH

// Property checked only while out of reset
`define RCA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define RCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/rca_pkg.sv
`default_nettype none
package rca_pkg;

  // Cell counts and widths of the item fields and registers
  localparam int CELL_MAX   = 64;
  localparam int CELLS_DEF  = 64;
  localparam int WORLD_W    = 64;
  localparam int GEN_W      = 32;
  localparam int RULE_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [RULE_W-1:0] RULE_RESET = 4'd1;
  localparam logic [GEN_W-1:0]  SNAP_RESET = 32'd100000;
  localparam logic [GEN_W-1:0]  GEN_MAX    = 32'hFFFF_FFFF;

  // Operation codes of an input item
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE     = 2'd0,
    CFG_SNAP_GEN = 2'd1
  } cfg_idx_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic load;       // take the loaded bit, clear snapshot
    logic step;       // advance one generation
    logic snap_save;  // copy the new world bit into the snapshot
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/rca_in_if.sv
`default_nettype none
interface rca_in_if;
  import rca_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [WORLD_W-1:0] load_cells;

  modport source (output valid, output func, output load_cells, input ready);
  modport sink   (input valid, input func, input load_cells, output ready);
endinterface
`default_nettype wire

// File: design/rca_out_if.sv
`default_nettype none
interface rca_out_if;
  import rca_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORLD_W-1:0] cells;
  logic [GEN_W-1:0]   generation_now;
  logic               repeat_found;
  logic [GEN_W-1:0]   repeat_at;

  modport source (output valid, output cells, output generation_now,
                  output repeat_found, output repeat_at, input ready);
  modport sink   (input valid, input cells, input generation_now,
                  input repeat_found, input repeat_at, output ready);
endinterface
`default_nettype wire

// File: design/rca_cfg_if.sv
`default_nettype none
interface rca_cfg_if;
  import rca_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: design/rca_cell.sv
`default_nettype none
module rca_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire rca_pkg::cell_ctrl_t    ctrl,
  input  wire [rca_pkg::RULE_W-1:0]   rule,
  input  wire                         left_in,
  input  wire                         right_in,
  input  wire                         load_bit,
  output logic                        world_o,
  output logic                        match_o
);
  import rca_pkg::*;

  logic world_r, world_nxt;
  logic snap_r,  snap_nxt;
  logic evolved;

  // Rule lookup from the two neighbors of the previous generation
  assign evolved = rule[{left_in, right_in}];

  always_comb begin
    world_nxt = world_r;
    snap_nxt  = snap_r;
    if (ctrl.load) begin
      world_nxt = load_bit;
      snap_nxt  = 1'b0;
    end else if (ctrl.step) begin
      world_nxt = evolved;
      if (ctrl.snap_save) begin
        snap_nxt = evolved;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_r <= 1'b0;
      snap_r  <= 1'b0;
    end else begin
      world_r <= world_nxt;
      snap_r  <= snap_nxt;
    end
  end

  assign world_o = world_r;
  // New bit against the stored snapshot, for the repeat check
  assign match_o = (evolved == snap_r);

endmodule
`default_nettype wire

// File: design/ring_cellular_automaton_cycle_check.sv
// Ring cellular automaton: CELLS one-bit cells, each in its own flop with its
// own snapshot bit, advance one generation per step item from their two ring
// neighbors through the 4-bit rule; a load item replaces the world and
// restarts the count. The block takes one item per clock and keeps that rate
// under any stall pattern that lets results drain: an item accepted at one
// edge has its result on the output channel from the next cycle, and a new
// item is taken whenever no result is waiting or the waiting one is taken in
// the same cycle. The clock period is set by the step path: the rule lookup in
// each cell, the AND of all cell match bits, and the saturating 32-bit
// generation increment with its compare against snapshot_generation. Cells
// above CELLS read as zero; configuration writes are taken in any cycle.
`default_nettype none
module ring_cellular_automaton_cycle_check #(
  parameter int CELLS = rca_pkg::CELLS_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  rca_in_if.sink          in_ch,
  rca_out_if.source       out_ch,
  rca_cfg_if.sink         cfg_ch
);
  import rca_pkg::*;

  logic                  out_valid_r, out_valid_nxt;
  logic [GEN_W-1:0]      gen_r, gen_nxt;
  logic [GEN_W-1:0]      repeat_r, repeat_nxt;
  logic [RULE_W-1:0]     rule_r, rule_nxt;
  logic [GEN_W-1:0]      snap_gen_r, snap_gen_nxt;

  logic                  accept;
  logic                  step_acc;
  logic                  load_acc;
  logic [GEN_W-1:0]      gen_inc;
  logic                  check_en;
  logic                  all_match;
  logic [CELLS-1:0]      world_vec;
  logic [CELLS-1:0]      match_vec;
  cell_ctrl_t            ctrl;

  // Input handshake: free output slot or one being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_acc    = accept && (in_ch.func == FUNC_LOAD);
  assign step_acc    = accept && (in_ch.func == FUNC_STEP);

  // Saturating generation count for this step
  assign gen_inc = (gen_r == GEN_MAX) ? gen_r : gen_r + GEN_W'(1);

  // Checks run once the snapshot generation is reached and no repeat is held
  assign check_en  = (gen_inc >= snap_gen_r) && (repeat_r == '0);
  assign all_match = &match_vec;

  always_comb begin
    ctrl.load      = load_acc;
    ctrl.step      = step_acc;
    ctrl.snap_save = check_en && (gen_inc == snap_gen_r);
  end

  // Chain of cells closed into a ring
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? CELLS - 1 : i - 1;
    localparam int RIGHT = (i == CELLS - 1) ? 0 : i + 1;
    rca_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .rule     (rule_r),
      .left_in  (world_vec[LEFT]),
      .right_in (world_vec[RIGHT]),
      .load_bit (in_ch.load_cells[i]),
      .world_o  (world_vec[i]),
      .match_o  (match_vec[i])
    );
  end

  // Generation counter, repeat record and output valid
  always_comb begin
    gen_nxt       = gen_r;
    repeat_nxt    = repeat_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
    if (load_acc) begin
      gen_nxt    = '0;
      repeat_nxt = '0;
    end else if (step_acc) begin
      gen_nxt = gen_inc;
      if (check_en && (gen_inc != snap_gen_r) && all_match) begin
        repeat_nxt = gen_inc;
      end
    end
  end

  // Configuration register writes
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    rule_nxt     = rule_r;
    snap_gen_nxt = snap_gen_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_RULE:     rule_nxt     = cfg_ch.data[RULE_W-1:0];
        CFG_SNAP_GEN: snap_gen_nxt = cfg_ch.data[GEN_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      gen_r       <= '0;
      repeat_r    <= '0;
      rule_r      <= RULE_RESET;
      snap_gen_r  <= SNAP_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      gen_r       <= gen_nxt;
      repeat_r    <= repeat_nxt;
      rule_r      <= rule_nxt;
      snap_gen_r  <= snap_gen_nxt;
    end
  end

  // Result is the state itself; it only changes when an item is accepted
  assign out_ch.valid          = out_valid_r;
  assign out_ch.cells          = WORLD_W'(world_vec);
  assign out_ch.generation_now = gen_r;
  assign out_ch.repeat_found   = (repeat_r != '0);
  assign out_ch.repeat_at      = repeat_r;

endmodule
`default_nettype wire

// File: design/rca_checker.sv
`default_nettype none
`include "ring_cellular_automaton_cycle_check_defines.svh"
module rca_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        in_func,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [rca_pkg::WORLD_W-1:0] out_cells,
  input wire [rca_pkg::GEN_W-1:0]   out_gen,
  input wire                        out_found,
  input wire [rca_pkg::GEN_W-1:0]   out_at
);
  import rca_pkg::*;

  logic acc;
  assign acc = in_valid && in_ready;

  // A load restarts the count and drops any repeat
  `RCA_ASSERT(a_load_restart, clk, rst_n, (acc && (in_func == FUNC_LOAD)) |=> (out_valid && (out_gen == '0) && !out_found), "load did not restart")

  // A step below saturation advances the count by one
  `RCA_ASSERT(a_step_count, clk, rst_n, (acc && (in_func == FUNC_STEP) && (out_gen != GEN_MAX)) |=> (out_gen == $past(out_gen) + GEN_W'(1)), "generation did not advance")

  // A recorded repeat is kept until the next load
  `RCA_ASSERT(a_repeat_held, clk, rst_n, (out_found && !(acc && (in_func == FUNC_LOAD))) |=> (out_found && $stable(out_at)), "repeat record changed")

  // A stalled result holds
  `RCA_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_cells)), "stalled result changed")

  // Reset empties the output
  `RCA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind ring_cellular_automaton_cycle_check rca_checker u_rca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_cells (out_ch.cells),
  .out_gen   (out_ch.generation_now),
  .out_found (out_ch.repeat_found),
  .out_at    (out_ch.repeat_at)
);
`default_nettype wire

// File: dv/tb_ring_cellular_automaton_cycle_check.sv
`default_nettype none
module tb_ring_cellular_automaton_cycle_check;
  timeunit 1ns;
  timeprecision 1ps;
  import rca_pkg::*;

  localparam int CELLS = CELLS_DEF;
  localparam logic [WORLD_W-1:0] RING_MASK =
    (CELLS >= WORLD_W) ? {WORLD_W{1'b1}} : ((64'd1 << CELLS) - 64'd1);
  localparam int PHASES          = 12;
  localparam int PHASE_ITEMS     = 120;
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int TAIL_CYCLES     = 8;

  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [WORLD_W-1:0] cells;
    logic [GEN_W-1:0]   generation_now;
    logic               repeat_found;
    logic [GEN_W-1:0]   repeat_at;
  } ca_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  func;
    logic [WORLD_W-1:0]    bits;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    ca_result_t            want;
  } dir_row_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;
  typedef enum logic [2:0] {PAT_RANDOM, PAT_PERIODIC, PAT_ONE_HOT, PAT_FLAT, PAT_SPARSE}
    pattern_t;

  logic clk;
  logic rst_n;

  rca_in_if  in_ch ();
  rca_out_if out_ch ();
  rca_cfg_if cfg_ch ();

  ring_cellular_automaton_cycle_check #(.CELLS(CELLS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the automaton state and its registers
  logic [RULE_W-1:0]  rule_q;
  logic [GEN_W-1:0]   snap_gen_q;
  logic [WORLD_W-1:0] world_q;
  logic [GEN_W-1:0]   gen_q;
  logic [WORLD_W-1:0] snap_world_q;
  logic [GEN_W-1:0]   repeat_gen_q;

  ca_result_t pending_results[$];
  dir_row_t   directed_rows[$];

  int mismatch_count = 0;
  int results_checked = 0;
  int loads_sent = 0;
  int steps_sent = 0;
  int reg_writes = 0;
  int repeats_seen = 0;
  int items_sent = 0;
  int burst_left = 0;
  int gap_max = 0;
  int holdoffs_asked = 0;
  int holdoffs_done = 0;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // One generation of the ring: new cell is rule[{left, right}]
  function automatic logic [WORLD_W-1:0] next_generation(input logic [WORLD_W-1:0] w,
                                                         input logic [RULE_W-1:0] r);
    logic [WORLD_W-1:0] nxt;
    logic [1:0]         nb;
    nxt = '0;
    for (int i = 0; i < CELLS; i++) begin
      nb = {w[(i + CELLS - 1) % CELLS], w[(i + 1) % CELLS]};
      nxt[i] = r[nb];
    end
    return nxt & RING_MASK;
  endfunction

  // Advance the shadow state by one item and return the result it yields
  function automatic ca_result_t predict_item(input logic func,
                                              input logic [WORLD_W-1:0] bits);
    ca_result_t r;
    if (func == FUNC_LOAD) begin
      world_q      = bits & RING_MASK;
      gen_q        = '0;
      snap_world_q = '0;
      repeat_gen_q = '0;
    end else begin
      world_q = next_generation(world_q, rule_q);
      if (gen_q != GEN_MAX) gen_q = gen_q + 1'b1;
      // snapshot and repeat checks only once the snapshot generation is reached
      if (gen_q >= snap_gen_q && repeat_gen_q == '0) begin
        if (gen_q == snap_gen_q) begin
          snap_world_q = world_q;
        end else if (world_q == snap_world_q) begin
          repeat_gen_q = gen_q;
          repeats_seen++;
        end
      end
    end
    r.cells          = world_q;
    r.generation_now = gen_q;
    r.repeat_found   = (repeat_gen_q != '0);
    r.repeat_at      = repeat_gen_q;
    return r;
  endfunction

  function automatic dir_row_t row_item(input logic func, input logic [WORLD_W-1:0] bits);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.func = func;
    row.bits = bits;
    return row;
  endfunction

  function automatic dir_row_t row_typed(input logic func, input logic [WORLD_W-1:0] bits,
                                         input logic [WORLD_W-1:0] cells,
                                         input logic [GEN_W-1:0] gen, input logic found,
                                         input logic [GEN_W-1:0] at);
    dir_row_t row;
    row = '0;
    row.kind = ROW_TYPED;
    row.func = func;
    row.bits = bits;
    row.want = '{cells: cells, generation_now: gen, repeat_found: found, repeat_at: at};
    return row;
  endfunction

  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  // Offer one item in bursts with random gaps; predict it once accepted
  task automatic send_item(input logic func, input logic [WORLD_W-1:0] bits,
                           input bit typed, input ca_result_t typed_result);
    int         gap;
    ca_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.load_cells <= bits;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = predict_item(func, bits);
    if (typed) r = typed_result;
    pending_results.push_back(r);
    items_sent++;
    if (func == FUNC_LOAD) loads_sent++;
    else steps_sent++;
    @(negedge clk);
  endtask

  // Block is idle once every predicted result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_RULE) rule_q = data[RULE_W-1:0];
    else if (idx == CFG_SNAP_GEN) snap_gen_q = data;
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    ca_result_t got;
    ca_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.cells          = out_ch.cells;
      got.generation_now = out_ch.generation_now;
      got.repeat_found   = out_ch.repeat_found;
      got.repeat_at      = out_ch.repeat_at;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: cells %h generation %0d", got.cells,
               got.generation_now);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.cells !== want.cells) begin
          $error("cells: expected %h, actual %h", want.cells, got.cells);
          mismatch_count++;
        end
        if (got.generation_now !== want.generation_now) begin
          $error("generation_now: expected %0d, actual %0d", want.generation_now,
                 got.generation_now);
          mismatch_count++;
        end
        if (got.repeat_found !== want.repeat_found) begin
          $error("repeat_found: expected %b, actual %b", want.repeat_found, got.repeat_found);
          mismatch_count++;
        end
        if (got.repeat_at !== want.repeat_at) begin
          $error("repeat_at: expected %0d, actual %0d", want.repeat_at, got.repeat_at);
          mismatch_count++;
        end
      end
    end
  end

  // Result receiver: stall patterns in stretches, plus long hold-offs on request
  initial begin
    sink_mode_t mode;
    int         stretch;
    int         cyc;
    out_ch.ready = 1'b0;
    cyc = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (holdoffs_done < holdoffs_asked) begin
        holdoffs_done++;
        for (int n = 0; n < HOLDOFF_CYCLES; n++) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end else begin
        mode    = sink_mode_t'($urandom_range(0, 3));
        stretch = $urandom_range(8, 120);
        for (int n = 0; n < stretch; n++) begin
          @(negedge clk);
          cyc++;
          case (mode)
            SINK_OPEN:     out_ch.ready <= 1'b1;
            SINK_MOSTLY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
            SINK_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
            SINK_PERIODIC: out_ch.ready <= (cyc % 3 != 0);
            default:       out_ch.ready <= 1'b1;
          endcase
        end
      end
    end
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus
  initial begin
    logic [RULE_W-1:0]  rule_pick;
    logic [GEN_W-1:0]   snap_pick;
    logic [WORLD_W-1:0] pat;
    logic [WORLD_W-1:0] seed;
    pattern_t           pk;
    int                 period;
    int                 steps;
    int                 target;

    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_LOAD;
    in_ch.load_cells = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_RULE;
    cfg_ch.data      = '0;
    rst_n            = 1'b0;

    rule_q       = RULE_RESET;
    snap_gen_q   = SNAP_RESET;
    world_q      = '0;
    gen_q        = '0;
    snap_world_q = '0;
    repeat_gen_q = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: reset state, extremes, snapshot at zero, spare indexes
    directed_rows.push_back(row_item(FUNC_STEP, '0));
    directed_rows.push_back(row_typed(FUNC_LOAD, '1, '1, '0, 1'b0, '0));
    directed_rows.push_back(row_item(FUNC_STEP, '0));
    directed_rows.push_back(row_typed(FUNC_LOAD, '0, '0, '0, 1'b0, '0));
    directed_rows.push_back(row_typed(FUNC_LOAD, 64'h8000_0000_0000_0001,
                                      64'h8000_0000_0000_0001, '0, 1'b0, '0));
    directed_rows.push_back(row_item(FUNC_STEP, '1));
    directed_rows.push_back(row_item(FUNC_STEP, '0));
    directed_rows.push_back(row_cfg(CFG_RULE, 32'hFFFF_FFFF));
    directed_rows.push_back(row_item(FUNC_STEP, '0));
    directed_rows.push_back(row_cfg(CFG_RULE, 32'hFFFF_FFF0));
    directed_rows.push_back(row_cfg(CFG_SNAP_GEN, 32'd0));
    directed_rows.push_back(row_typed(FUNC_LOAD, 64'hDEAD_BEEF_0123_4567,
                                      64'hDEAD_BEEF_0123_4567, '0, 1'b0, '0));
    // rule zero empties the ring, which matches the cleared snapshot at once
    directed_rows.push_back(row_typed(FUNC_STEP, '1, '0, 32'd1, 1'b1, 32'd1));
    directed_rows.push_back(row_typed(FUNC_STEP, '0, '0, 32'd2, 1'b1, 32'd1));
    directed_rows.push_back(row_cfg(CFG_RULE, 32'd6));
    directed_rows.push_back(row_cfg(CFG_SNAP_GEN, 32'd2));
    directed_rows.push_back(row_typed(FUNC_LOAD, 64'h1, 64'h1, '0, 1'b0, '0));
    repeat (6) directed_rows.push_back(row_item(FUNC_STEP, 64'h5555_AAAA_5555_AAAA));
    directed_rows.push_back(row_cfg(CFG_SNAP_GEN, GEN_MAX));
    directed_rows.push_back(row_typed(FUNC_LOAD, '1, '1, '0, 1'b0, '0));
    directed_rows.push_back(row_item(FUNC_STEP, '0));
    directed_rows.push_back(row_cfg(CFG_SPARE_A, 32'h0000_0003));
    directed_rows.push_back(row_cfg(CFG_SPARE_B, 32'hFFFF_FFFF));
    // shift rule on a period-4 world repeats four steps after the snapshot
    directed_rows.push_back(row_cfg(CFG_RULE, 32'hA));
    directed_rows.push_back(row_cfg(CFG_SNAP_GEN, 32'd1));
    directed_rows.push_back(row_typed(FUNC_LOAD, 64'h1111_1111_1111_1111,
                                      64'h1111_1111_1111_1111, '0, 1'b0, '0));
    repeat (5) directed_rows.push_back(row_item(FUNC_STEP, '0));

    gap_max = 3;
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          wait_drained();
          write_reg(directed_rows[i].idx, directed_rows[i].data);
        end
        ROW_TYPED: send_item(directed_rows[i].func, directed_rows[i].bits, 1'b1,
                             directed_rows[i].want);
        default:   send_item(directed_rows[i].func, directed_rows[i].bits, 1'b0, '0);
      endcase
    end

    // Random part: one rule and one snapshot generation setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case ($urandom_range(0, 11))
        0:       rule_pick = 4'h0;
        1:       rule_pick = 4'hF;
        2:       rule_pick = 4'hA;
        3:       rule_pick = 4'hC;
        4:       rule_pick = 4'h5;
        5:       rule_pick = 4'h3;
        6:       rule_pick = 4'h6;
        7:       rule_pick = 4'h9;
        default: rule_pick = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 9))
        6:       snap_pick = '0;
        7:       snap_pick = GEN_MAX;
        8:       snap_pick = $urandom;
        9:       snap_pick = $urandom_range(25, 200);
        default: snap_pick = $urandom_range(0, 24);
      endcase
      write_reg(CFG_RULE, {28'($urandom), rule_pick});
      write_reg(CFG_SNAP_GEN, snap_pick);

      // long receiver hold-off with the sender pushing back-to-back
      if (ph == 2 || ph == 7) begin
        holdoffs_asked++;
        gap_max = 0;
      end else begin
        gap_max = (ph % 4 == 0) ? 0 : $urandom_range(1, 10);
      end

      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: random mix of loads and steps
          repeat ($urandom_range(1, 8))
            send_item(1'($urandom), {$urandom, $urandom}, 1'b0, '0);
        end else begin
          // well-formed: load a world, then run it for a while
          pk = pattern_t'($urandom_range(0, 5));
          case (pk)
            PAT_PERIODIC: begin
              period = 1 << $urandom_range(0, 5);
              seed = {$urandom, $urandom} & ((64'd1 << period) - 64'd1);
              pat = '0;
              for (int b = 0; b < WORLD_W; b += period) pat |= seed << b;
            end
            PAT_ONE_HOT: pat = 64'd1 << $urandom_range(0, WORLD_W - 1);
            PAT_FLAT:    pat = $urandom_range(0, 1) ? '1 : '0;
            PAT_SPARSE:  pat = {$urandom, $urandom} & {$urandom, $urandom}
                               & {$urandom, $urandom};
            default:     pat = {$urandom, $urandom};
          endcase
          send_item(FUNC_LOAD, pat, 1'b0, '0);
          steps = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                              : $urandom_range(3, 30);
          repeat (steps) send_item(FUNC_STEP, {$urandom, $urandom}, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d loads and %0d steps over %0d register writes",
             loads_sent, steps_sent, reg_writes);
    $display("%0d results checked, %0d repeat detections predicted",
             results_checked, repeats_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
